>>> hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

    // Bitmap geometry: one bit per frame, 32 frames per word.
    localparam int NUM_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;
    // Word counter holds the word count itself, so one bit wider than an address.
    localparam int WCNT_W     = WADDR_W + 1;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = COUNT_W'(NUM_FRAMES);
    localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};

    // Request codes.
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_FREED = 2'd1,
        ST_NOP   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    // Input item.
    typedef struct packed {
        req_type_t            req_type;
        logic [FRAME_W-1:0]   page_frame;
        logic                 kernel_only;
        logic                 writable;
    } fba_req_t;

    // Result item.
    typedef struct packed {
        status_t              status;
        logic [FRAME_W-1:0]   new_frame;
        logic                 present_bit;
        logic                 rw_bit;
        logic                 user_bit;
    } fba_rsp_t;

endpackage

>>> hw/rtl/fba_ram.sv
`timescale 1ns / 1ps

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/frame_bitmap_allocator.sv
`timescale 1ns / 1ps

// First-fit page frame allocator over a used-frame bitmap of 128 words x 32 bits.
// Input channel (in_valid/in_ready/in_data) takes one allocate or free request per item;
// output channel (out_valid/out_ready/out_data) returns exactly one result per item.
// cfg_we/cfg_data write frame_count, which bounds the search to frame_count/32 words;
// write it only while the block is idle.
// An allocate with a nonzero frame or a free of frame 0 goes through S_DONE to the output
// register. A free reads, then writes back, the bitmap word. An allocate scans the words
// in order; the bitmap RAM read port delivers one word per cycle while it scans.
// One item is in work at a time; in_ready is high only while the sequencer is idle.
// A finished result waits in its own state until the output register is free, and the
// next item can be accepted while a result sits in the output register.
// Reset clears every word's valid bit, so the whole bitmap reads as free at once with
// no clearing pass; frame_count returns to 4096.
// When the receiver stalls, out_data holds; at most one further item completes and then
// waits for the output register.
module frame_bitmap_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  fba_pkg::fba_req_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output fba_pkg::fba_rsp_t            out_data,
    input  logic                         cfg_we,
    input  logic [fba_pkg::COUNT_W-1:0]  cfg_data
);

    import fba_pkg::*;

    // Control and payload registers.
    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     frame_count_reg;
    fba_req_t               req_reg, req_next;
    fba_rsp_t               res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    fba_rsp_t               out_data_reg, out_data_next;
    logic [WCNT_W-1:0]      limit_reg, limit_next;
    logic [WCNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                   pend_reg, pend_next;
    logic [WADDR_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [MAP_WORDS-1:0]   word_valid_reg;
    logic                   rd_valid_reg;

    // RAM port signals.
    logic                   ram_we;
    logic [WADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [WADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic [WORD_BITS-1:0]   word_eff;
    logic [BIT_W-1:0]       zero_bit;
    logic [WCNT_W-1:0]      words_in_cfg;
    logic                   issue_ok;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A word never written since reset reads as all free.
    assign word_eff = rd_valid_reg ? ram_rdata : '0;

    // Lowest zero bit of the word just read.
    always_comb
    begin
        zero_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_eff[i])
            begin
                zero_bit = BIT_W'(i);
            end
        end
    end

    // Words to search: frame_count/32, saturated at the bitmap depth.
    always_comb
    begin
        if (frame_count_reg[COUNT_W-1:BIT_W] > (COUNT_W - BIT_W)'(MAP_WORDS))
        begin
            words_in_cfg = WCNT_W'(MAP_WORDS);
        end
        else
        begin
            words_in_cfg = WCNT_W'(frame_count_reg[COUNT_W-1:BIT_W]);
        end
    end

    assign issue_ok = issue_idx_reg < limit_reg;

    // Sequencer: next state, RAM controls and result.
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        limit_next     = limit_reg;
        issue_idx_next = issue_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next = in_data;
                    res_next = '{status: ST_NOP, new_frame: '0, present_bit: 1'b0,
                                 rw_bit: 1'b0, user_bit: 1'b0};
                    if (in_data.req_type == REQ_ALLOC)
                    begin
                        if (in_data.page_frame != '0)
                        begin
                            res_next.new_frame = in_data.page_frame;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            limit_next     = words_in_cfg;
                            issue_idx_next = '0;
                            pend_next      = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    else if (in_data.page_frame == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = in_data.page_frame[FRAME_W-1:BIT_W];
                        state_next = S_FREE_RD;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && word_eff != WORD_FULL)
                begin
                    // Take the lowest free frame of the first word that is not full.
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg;
                    ram_wdata = word_eff | (WORD_BITS'(1) << zero_bit);
                    res_next  = '{status: ST_ALLOC,
                                  new_frame: {pend_idx_reg, zero_bit},
                                  present_bit: 1'b1,
                                  rw_bit: req_reg.writable,
                                  user_bit: !req_reg.kernel_only};
                    state_next = S_DONE;
                end
                else if (!issue_ok)
                begin
                    // Every searched word is full, or no word is searched.
                    res_next = '{status: ST_FULL, new_frame: '0, present_bit: 1'b0,
                                 rw_bit: 1'b0, user_bit: 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    // Issue the next word read while the previous one is checked.
                    ram_re         = 1'b1;
                    ram_raddr      = issue_idx_reg[WADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_idx_next  = issue_idx_reg[WADDR_W-1:0];
                    issue_idx_next = issue_idx_reg + WCNT_W'(1);
                end
            end

            S_FREE_RD:
            begin
                state_next = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = req_reg.page_frame[FRAME_W-1:BIT_W];
                ram_wdata = word_eff & ~(WORD_BITS'(1) << req_reg.page_frame[BIT_W-1:0]);
                res_next  = '{status: ST_FREED, new_frame: '0, present_bit: 1'b0,
                              rw_bit: 1'b0, user_bit: 1'b0};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            frame_count_reg <= FRAME_COUNT_RST;
            word_valid_reg  <= '0;
            rd_valid_reg    <= 1'b0;
            pend_reg        <= 1'b0;
            issue_idx_reg   <= '0;
            limit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            issue_idx_reg <= issue_idx_next;
            limit_reg     <= limit_next;
            if (cfg_we)
            begin
                frame_count_reg <= cfg_data;
            end
            if (ram_re)
            begin
                rd_valid_reg <= word_valid_reg[ram_raddr];
            end
            if (ram_we)
            begin
                word_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        pend_idx_reg <= pend_idx_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/fba_checker.sv
`timescale 1ns / 1ps

module fba_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  fba_pkg::fba_rsp_t            out_data
);

    import fba_pkg::*;

    // The block works on one item at a time.
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("in_ready high right after an item was accepted");

    // A stalled result holds.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed or dropped while stalled");

    // Only an allocation sets the page entry flags.
    property p_flags_only_on_alloc;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_ALLOC) |->
            (!out_data.present_bit && !out_data.rw_bit && !out_data.user_bit);
    endproperty
    a_flags_only_on_alloc: assert property (p_flags_only_on_alloc)
        else $error("flags set on a result that is not an allocation");

    // An allocation is always marked present.
    property p_alloc_present;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_ALLOC) |-> out_data.present_bit;
    endproperty
    a_alloc_present: assert property (p_alloc_present)
        else $error("allocation without present bit");

    // Free and full results carry frame zero.
    property p_zero_frame;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_FREED || out_data.status == ST_FULL)) |->
            (out_data.new_frame == '0);
    endproperty
    a_zero_frame: assert property (p_zero_frame)
        else $error("free or full result with nonzero frame");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
